// ===== rtl/keyed_slot_table_defines.svh =====
// keyed_slot_table_defines.svh: assertion macros for the keyed slot table rtl
// no dependencies; the including module supplies clk and arst_n
`ifndef KEYED_SLOT_TABLE_DEFINES_SVH
`define KEYED_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, checked at every clock outside reset
`define KST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed_slot_table assertion failed");

// next-cycle implication, checked at every clock outside reset
`define KST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed_slot_table assertion failed");

`endif

// ===== rtl/kst_pkg.sv =====
// kst_pkg: request codes, sequencer states and fixed port widths of the slot table
// no dependencies
`timescale 1ns / 1ps

package kst_pkg;

	localparam int SLOT_OUT_BITS = 8;
	localparam int KEY_PORT_BITS = 32;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_PEEK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/kst_mem.sv =====
// kst_mem: single-port-write, single-port-read slot memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module kst_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/keyed_slot_table.sv =====
// keyed_slot_table: slot allocator with key lookup, scanning one slot per cycle
// depends on kst_pkg, kst_mem and keyed_slot_table_defines.svh
`timescale 1ns / 1ps
`include "keyed_slot_table_defines.svh"

// channel   signals                              beat moves when
// request   req_valid req_ready req_type         req_valid && req_ready
//           conn_key slot_in
// response  rsp_valid rsp_ready status           rsp_valid && rsp_ready
//           slot_out key_out
//
// allocate, free and lookup walk the slot memory one entry per cycle through its
// single read port, from slot 0 up to the first match or the last slot; the block
// takes no new request until the item's response is loaded. read by slot goes
// through a single peek step, and skips it for a slot number past the end of the table.
// after reset a clearing pass zeroes the used flags, and req_ready stays low meanwhile;
// a held response only stalls the sequencer in its final step.

module keyed_slot_table #(
	parameter int SLOT_COUNT = 256,
	parameter int KEY_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [1:0]                          req_type,
	input  logic [kst_pkg::KEY_PORT_BITS-1:0]   conn_key,
	input  logic [kst_pkg::SLOT_OUT_BITS-1:0]   slot_in,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic                                status,
	output logic [kst_pkg::SLOT_OUT_BITS-1:0]   slot_out,
	output logic [kst_pkg::KEY_PORT_BITS-1:0]   key_out
);

	localparam int AW = $clog2(SLOT_COUNT);
	localparam int MW = KEY_BITS + 1;

	kst_pkg::state_t state_q, state_d;
	kst_pkg::op_t    op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [AW-1:0]       chk_q;
	logic                res_status_q;
	logic [KEY_BITS-1:0] res_key_q;

	logic                               rsp_valid_q;
	logic                               status_q;
	logic [kst_pkg::SLOT_OUT_BITS-1:0]  slot_q;
	logic [kst_pkg::KEY_PORT_BITS-1:0]  key_out_q;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [MW-1:0] wr_data;
	logic [AW-1:0] rd_addr;
	logic [MW-1:0] rd_data;

	logic                rd_used;
	logic [KEY_BITS-1:0] rd_key;
	logic                match;
	logic                last;
	logic                slot_ok;
	logic                accept;
	logic                load_out;

	kst_mem #(
		.DEPTH(SLOT_COUNT),
		.WIDTH(MW)
	) u_mem (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign rd_used = rd_data[KEY_BITS];
	assign rd_key  = rd_data[KEY_BITS-1:0];
	assign last    = (chk_q == AW'(SLOT_COUNT - 1));
	assign slot_ok = (32'(slot_in) < SLOT_COUNT);
	assign accept  = req_valid && req_ready;

	// allocate hunts for a free slot, everything else for a used one
	always_comb begin
		if (op_q == kst_pkg::OP_ALLOC) begin
			match = !rd_used;
		end else begin
			match = rd_used && ((op_q == kst_pkg::OP_READ) || (rd_key == key_q));
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kst_pkg::ST_CLEAR: begin
				if (last) state_d = kst_pkg::ST_IDLE;
			end
			kst_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (kst_pkg::op_t'(req_type) != kst_pkg::OP_READ) begin
						state_d = kst_pkg::ST_SCAN;
					end else if (slot_ok) begin
						state_d = kst_pkg::ST_PEEK;
					end else begin
						state_d = kst_pkg::ST_DONE;
					end
				end
			end
			kst_pkg::ST_SCAN: begin
				if (match || last) state_d = kst_pkg::ST_DONE;
			end
			kst_pkg::ST_PEEK: begin
				state_d = kst_pkg::ST_DONE;
			end
			kst_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = kst_pkg::ST_IDLE;
			end
			default: begin
				state_d = kst_pkg::ST_CLEAR;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_ready = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = chk_q;
		wr_data   = '0;
		rd_addr   = chk_q;
		load_out  = 1'b0;
		case (state_q)
			kst_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
			end
			kst_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (kst_pkg::op_t'(req_type) == kst_pkg::OP_READ) begin
					rd_addr = slot_ok ? AW'(slot_in) : '0;
				end else begin
					rd_addr = '0;
				end
			end
			kst_pkg::ST_SCAN: begin
				// read data is registered, so it arrives in the cycle after the address
				rd_addr = last ? '0 : AW'(chk_q + 1'b1);
				if (match && (op_q == kst_pkg::OP_ALLOC)) begin
					wr_en   = 1'b1;
					wr_data = {1'b1, key_q};
				end else if (match && (op_q == kst_pkg::OP_FREE)) begin
					wr_en   = 1'b1;
					wr_data = {1'b0, rd_key};
				end
			end
			kst_pkg::ST_PEEK: begin
			end
			kst_pkg::ST_DONE: begin
				load_out = !rsp_valid_q || rsp_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= kst_pkg::ST_CLEAR;
			chk_q        <= '0;
			res_status_q <= 1'b1;
			op_q         <= kst_pkg::OP_ALLOC;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				kst_pkg::ST_CLEAR: begin
					chk_q <= last ? '0 : AW'(chk_q + 1'b1);
				end
				kst_pkg::ST_IDLE: begin
					if (accept) begin
						op_q         <= kst_pkg::op_t'(req_type);
						res_status_q <= 1'b1;
						if (kst_pkg::op_t'(req_type) == kst_pkg::OP_READ && slot_ok) begin
							chk_q <= AW'(slot_in);
						end else begin
							chk_q <= '0;
						end
					end
				end
				kst_pkg::ST_SCAN: begin
					if (match) begin
						res_status_q <= 1'b0;
					end else if (!last) begin
						chk_q <= AW'(chk_q + 1'b1);
					end
				end
				kst_pkg::ST_PEEK: begin
					if (match) res_status_q <= 1'b0;
				end
				default: begin
				end
			endcase
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q     <= KEY_BITS'(conn_key);
			res_key_q <= '0;
		end
		if (match && (state_q == kst_pkg::ST_SCAN || state_q == kst_pkg::ST_PEEK)) begin
			res_key_q <= (op_q == kst_pkg::OP_ALLOC) ? key_q : rd_key;
		end
		if (load_out) begin
			status_q  <= res_status_q;
			slot_q    <= res_status_q ? '0 : kst_pkg::SLOT_OUT_BITS'(chk_q);
			key_out_q <= res_status_q ? '0 : kst_pkg::KEY_PORT_BITS'(res_key_q);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign slot_out  = slot_q;
	assign key_out   = key_out_q;

	`KST_ASSERT_NOW(a_no_write_when_ready, req_ready, !wr_en)
	`KST_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready)
	`KST_ASSERT_NOW(a_fail_zeroes_payload, rsp_valid && status, slot_out == '0 && key_out == '0)
	`KST_ASSERT_NOW(a_claim_only_on_alloc, wr_en && wr_data[KEY_BITS], op_q == kst_pkg::OP_ALLOC)

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for keyed_slot_table, with a slot table predictor
// walks a directed script, fills the table, then runs a random mix of requests
// depends on kst_pkg and the keyed_slot_table rtl
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic        st;
		logic [7:0]  slot;
		logic [31:0] key;
	} slot_rsp_t;

	typedef struct {
		kst_pkg::op_t op;
		logic [31:0]  key;
		logic [7:0]   idx;
		bit           typed;
		slot_rsp_t    rsp;
	} dir_row_t;

	localparam int        SLOTS = 256;
	localparam slot_rsp_t MISS  = '{st: 1'b1, slot: 8'd0, key: 32'd0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	logic [1:0]  req_type = kst_pkg::OP_ALLOC;
	logic [31:0] conn_key = '0;
	logic [7:0]  slot_in = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	logic        status;
	logic [7:0]  slot_out;
	logic [31:0] key_out;

	// predictor copy of the table
	bit          live_flag [SLOTS];
	logic [31:0] held_key [SLOTS];
	int          live_count = 0;

	slot_rsp_t   rsp_due [$];
	int          mismatch_count = 0;
	int          rsp_seen = 0;
	bit          calm = 1'b0;

	logic [31:0] common_keys [4] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000};

	// directed script; typed rows carry an expectation that is plain from the spec
	dir_row_t dir_rows [18] = '{
		'{kst_pkg::OP_READ,   32'h0,         8'd0,   1'b1, MISS},
		'{kst_pkg::OP_READ,   32'hFFFF_FFFF, 8'd255, 1'b1, MISS},
		'{kst_pkg::OP_FREE,   32'h0,         8'd0,   1'b1, MISS},
		'{kst_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 8'd255, 1'b1, MISS},
		'{kst_pkg::OP_ALLOC,  32'h0,         8'd255, 1'b1, '{1'b0, 8'd0, 32'h0}},
		'{kst_pkg::OP_ALLOC,  32'hFFFF_FFFF, 8'd0,   1'b1, '{1'b0, 8'd1, 32'hFFFF_FFFF}},
		'{kst_pkg::OP_ALLOC,  32'h0,         8'd0,   1'b1, '{1'b0, 8'd2, 32'h0}},
		'{kst_pkg::OP_LOOKUP, 32'h0,         8'd0,   1'b1, '{1'b0, 8'd0, 32'h0}},
		'{kst_pkg::OP_READ,   32'h0,         8'd1,   1'b1, '{1'b0, 8'd1, 32'hFFFF_FFFF}},
		'{kst_pkg::OP_FREE,   32'h0,         8'd0,   1'b1, '{1'b0, 8'd0, 32'h0}},
		'{kst_pkg::OP_LOOKUP, 32'h0,         8'd0,   1'b0, MISS},
		'{kst_pkg::OP_READ,   32'hFFFF_FFFF, 8'd0,   1'b1, MISS},
		'{kst_pkg::OP_ALLOC,  32'hA5A5_5A5A, 8'd0,   1'b0, MISS},
		'{kst_pkg::OP_FREE,   32'hFFFF_FFFF, 8'd0,   1'b0, MISS},
		'{kst_pkg::OP_READ,   32'h0,         8'd1,   1'b1, MISS},
		'{kst_pkg::OP_LOOKUP, 32'h1234_5678, 8'd0,   1'b1, MISS},
		'{kst_pkg::OP_READ,   32'hFFFF_FFFF, 8'd2,   1'b0, MISS},
		'{kst_pkg::OP_ALLOC,  32'h5A5A_A5A5, 8'd255, 1'b0, MISS}
	};

	keyed_slot_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req_type),
		.conn_key  (conn_key),
		.slot_in   (slot_in),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.slot_out  (slot_out),
		.key_out   (key_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// serves one request against the predictor table and returns its response
	function automatic slot_rsp_t serve_request(kst_pkg::op_t op, logic [31:0] key,
			logic [7:0] idx);
		int hit;
		slot_rsp_t r;
		hit = -1;
		case (op)
			kst_pkg::OP_ALLOC: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!live_flag[i]) begin
						hit = i;
						break;
					end
				end
				if (hit >= 0) begin
					live_flag[hit] = 1'b1;
					held_key[hit] = key;
					live_count++;
				end
			end
			kst_pkg::OP_FREE, kst_pkg::OP_LOOKUP: begin
				for (int i = 0; i < SLOTS; i++) begin
					if (live_flag[i] && held_key[i] == key) begin
						hit = i;
						break;
					end
				end
				if (hit >= 0 && op == kst_pkg::OP_FREE) begin
					live_flag[hit] = 1'b0;
					live_count--;
				end
			end
			default: begin
				if (live_flag[idx])
					hit = int'(idx);
			end
		endcase
		if (hit < 0)
			r = MISS;
		else
			r = '{st: 1'b0, slot: hit[7:0], key: held_key[hit]};
		return r;
	endfunction

	// half the time tries a key already in the table, so free and lookup find something
	function automatic logic [31:0] pick_conn_key();
		int unsigned s;
		logic [31:0] k;
		k = $urandom;
		case ($urandom_range(0, 3))
			0, 1: begin
				for (int t = 0; t < 8; t++) begin
					s = $urandom_range(0, SLOTS - 1);
					if (live_flag[s]) begin
						k = held_key[s];
						break;
					end
				end
			end
			2: k = common_keys[$urandom_range(0, 3)];
			default: ;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] pick_slot();
		int unsigned s;
		s = $urandom_range(0, SLOTS - 1);
		if ($urandom_range(0, 4) < 3) begin
			for (int t = 0; t < 8 && !live_flag[s]; t++)
				s = $urandom_range(0, SLOTS - 1);
		end
		return s[7:0];
	endfunction

	// offers one request beat and records its expected response on acceptance
	task automatic issue(input kst_pkg::op_t op, input logic [31:0] key,
			input logic [7:0] idx, input bit typed, input slot_rsp_t typed_rsp);
		slot_rsp_t predicted;
		if (!calm && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= op;
		conn_key <= key;
		slot_in <= idx;
		do @(posedge clk); while (!req_ready);
		predicted = serve_request(op, key, idx);
		rsp_due.push_back(typed ? typed_rsp : predicted);
	endtask

	initial begin
		kst_pkg::op_t op;
		int unsigned r;
		bit grow;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			issue(dir_rows[i].op, dir_rows[i].key, dir_rows[i].idx,
				dir_rows[i].typed, dir_rows[i].rsp);

		// sender waits for the table to catch up
		req_valid <= 1'b0;
		do @(posedge clk); while (rsp_due.size() != 0);

		// fill the table, then hit it while full
		while (live_count < SLOTS)
			issue(kst_pkg::OP_ALLOC, $urandom, 8'($urandom), 1'b0, MISS);
		issue(kst_pkg::OP_ALLOC, $urandom, 8'($urandom), 1'b1, MISS);
		issue(kst_pkg::OP_READ, $urandom, 8'd255, 1'b0, MISS);
		issue(kst_pkg::OP_LOOKUP, held_key[SLOTS-1], 8'($urandom), 1'b0, MISS);

		for (int n = 0; n < 680; n++) begin
			calm = (n >= 580);
			grow = ((n / 200) % 2) == 1;
			r = $urandom_range(0, 99);
			if (r < 60)
				op = grow ? kst_pkg::OP_ALLOC : kst_pkg::OP_FREE;
			else if (r < 75)
				op = grow ? kst_pkg::OP_FREE : kst_pkg::OP_ALLOC;
			else if (r < 90)
				op = kst_pkg::OP_LOOKUP;
			else
				op = kst_pkg::OP_READ;
			issue(op, pick_conn_key(), pick_slot(), 1'b0, MISS);
		end

		req_valid <= 1'b0;
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// response side: checks each beat and drives rsp_ready with stall bursts
	initial begin
		int unsigned hold_left;
		bit long_hold_done;
		slot_rsp_t want;
		hold_left = 0;
		long_hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (rsp_due.size() == 0) begin
					$error("response beat with nothing expected");
					mismatch_count++;
				end else begin
					want = rsp_due.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						mismatch_count++;
					end
					if (slot_out !== want.slot) begin
						$error("slot_out: expected %0d, got %0d", want.slot, slot_out);
						mismatch_count++;
					end
					if (key_out !== want.key) begin
						$error("key_out: expected %h, got %h", want.key, key_out);
						mismatch_count++;
					end
				end
			end
			// one long hold-off lets the request side back up
			if (rsp_seen == 300 && !long_hold_done) begin
				hold_left = 600;
				long_hold_done = 1'b1;
			end
			if (hold_left == 0 && !calm && $urandom_range(0, 7) == 0)
				hold_left = $urandom_range(1, 5);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
